// ===== sv/sm4_block_cipher_defines.svh =====
// Assertion macros for the SM4 cipher.
`ifndef SM4_BLOCK_CIPHER_DEFINES_SVH
`define SM4_BLOCK_CIPHER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SM4_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define SM4_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define SM4_ASSERT(lbl, clk, rst, prop)
`define SM4_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/sm4_pkg.sv =====
package sm4_pkg;

   localparam int ROUNDS = 32;
   localparam int RND_W = $clog2(ROUNDS);

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

   typedef enum logic [0:0] {
      REG_KEY_HIGH = 1'b0,
      REG_KEY_LOW  = 1'b1
   } reg_index_type;

   function automatic logic [31:0] subst_word(input logic [31:0] v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [31:0] data_transform(input logic [31:0] v);
      logic [31:0] b;
      b = subst_word(v);
      return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
   endfunction

   function automatic logic [31:0] key_transform(input logic [31:0] v);
      logic [31:0] b;
      b = subst_word(v);
      return b ^ rotl(b, 13) ^ rotl(b, 23);
   endfunction

   // Byte j of CK word i is (4*i + j) * 7 modulo 256, the first byte highest.
   function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
      logic [31:0] w;
      logic [7:0] base;
      w = '0;
      base = {1'b0, i, 2'b00};
      for (int j = 0; j < 4; j++) begin
         w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
      end
      return w;
   endfunction

endpackage

// ===== sv/sm4_block_cipher.sv =====
// SM4 block cipher with a 128-bit key and a fully unrolled pipeline of 32 rounds. An item
// enters in every cycle unless the output stalls or round keys are being expanded, and
// passes the input register and the 32 round registers; a stall halts all without loss.
// Reset and every key register write expand the 32 round keys, one key round a cycle; no
// item enters meanwhile. req_tuser selects encryption when high and decryption when low.
`include "sm4_block_cipher_defines.svh"
module sm4_block_cipher
   import sm4_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // block_high [63:0], block_low [127:64]
   input  logic         req_tuser,  // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // result_high [63:0], result_low [127:64]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   logic [63:0]      key_high_ff, key_low_ff;
   logic             load_ff, load_in;
   logic             busy_ff, busy_in;
   logic [RND_W-1:0] kcnt_ff, kcnt_in;
   logic [127:0]     kst_ff, kst_in;
   logic [31:0]      rk_ff [ROUNDS];
   logic [31:0]      nk;
   logic             cfg_wr;
   reg_index_type    cfg_idx;

   logic [127:0]     st_ff [ROUNDS+1];
   logic             vld_ff [ROUNDS+1];
   logic             fn_ff [ROUNDS+1];
   logic             adv;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx = reg_index_type'(csr_paddr[3]);
   assign csr_prdata = (cfg_idx == REG_KEY_LOW) ? key_low_ff : key_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            REG_KEY_LOW:  key_low_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   assign nk = kst_ff[127:96] ^
               key_transform(kst_ff[95:64] ^ kst_ff[63:32] ^ kst_ff[31:0] ^ ck_word(kcnt_ff));

   always_comb begin
      load_in = cfg_wr;
      busy_in = busy_ff;
      kcnt_in = kcnt_ff;
      kst_in = kst_ff;
      if (load_ff) begin
         busy_in = 1'b1;
         kcnt_in = '0;
         kst_in = {key_high_ff, key_low_ff} ^ FK;
      end else if (busy_ff) begin
         kst_in = {kst_ff[95:0], nk};
         kcnt_in = kcnt_ff + 1'b1;
         if (kcnt_ff == RND_W'(ROUNDS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b1;
         busy_ff <= 1'b0;
         kcnt_ff <= '0;
      end else begin
         load_ff <= load_in;
         busy_ff <= busy_in;
         kcnt_ff <= kcnt_in;
      end
      kst_ff <= kst_in;
      if (busy_ff && !load_ff) begin
         rk_ff[kcnt_ff] <= nk;
      end
   end

   assign adv = !vld_ff[ROUNDS] || rsp_tready;
   assign req_tready = adv && !load_ff && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid && req_tready;
      end
      if (adv) begin
         st_ff[0] <= {req_tdata[63:0], req_tdata[127:64]};
         fn_ff[0] <= req_tuser;
      end
   end

   for (genvar s = 0; s < ROUNDS; s++) begin : g_round
      logic [31:0]  rk;
      logic [127:0] st_in;
      assign rk = fn_ff[s] ? rk_ff[s] : rk_ff[ROUNDS-1-s];
      assign st_in = {st_ff[s][95:0], st_ff[s][127:96] ^
                      data_transform(st_ff[s][95:64] ^ st_ff[s][63:32] ^ st_ff[s][31:0] ^ rk)};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (adv) begin
            st_ff[s+1] <= st_in;
            fn_ff[s+1] <= fn_ff[s];
         end
      end
   end

   assign rsp_tvalid = vld_ff[ROUNDS];
   assign rsp_tdata = {st_ff[ROUNDS][95:64], st_ff[ROUNDS][127:96],
                       st_ff[ROUNDS][31:0], st_ff[ROUNDS][63:32]};

   `SM4_ASSERT(a_no_item_while_expanding, clock, reset, (req_tvalid && req_tready) |-> !busy_ff && !load_ff)
   `SM4_ASSERT(a_write_starts_expansion, clock, reset, cfg_wr |=> load_ff)
   `SM4_ASSERT(a_load_then_busy, clock, reset, load_ff |=> busy_ff)
   `SM4_ASSERT(a_expansion_ends, clock, reset, (busy_ff && !load_ff && !cfg_wr && kcnt_ff == RND_W'(ROUNDS - 1)) |=> !busy_ff)
   `SM4_ASSERT_ALWAYS(a_reset_loads, clock, reset |=> load_ff && !vld_ff[ROUNDS])

endmodule
